@@ rtl/core/frame_timestamp_match_queue_macros.svh @@
// assertion macros shared by the frame timestamp match queue
`ifndef FRAME_TIMESTAMP_MATCH_QUEUE_MACROS_SVH
`define FRAME_TIMESTAMP_MATCH_QUEUE_MACROS_SVH

// same-cycle implication, disabled in reset
`define FTMQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define FTMQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ftmq_pkg.sv @@
// types, codes and constants of the frame timestamp match queue
package ftmq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int TIME_W    = 52;
    localparam int CNT_OUT_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    localparam logic [19:0] USEC_PER_SEC  = 20'd1000000;
    localparam logic [8:0]  EARLY_STOP_US = 9'd400;
    localparam logic [10:0] TOL_DIVISOR   = 11'd2000;
    localparam logic [4:0]  CAP_RESET     = 5'd16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED   = 2'd1;

    // opcodes
    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_BACK   = 3'd2;
    localparam logic [2:0] OP_COUNT      = 3'd3;
    localparam logic [2:0] OP_MATCH      = 3'd4;

    // result status
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_CLOSED  = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_NOMATCH = 3'd4;

    // pointer commands
    localparam logic [2:0] PTR_HOLD = 3'd0;
    localparam logic [2:0] PTR_TOP  = 3'd1;
    localparam logic [2:0] PTR_ZERO = 3'd2;
    localparam logic [2:0] PTR_INC  = 3'd3;
    localparam logic [2:0] PTR_DEC  = 3'd4;
    localparam logic [2:0] PTR_POS1 = 3'd5;

    // memory write commands
    localparam logic [2:0] WR_NONE  = 3'd0;
    localparam logic [2:0] WR_BACK  = 3'd1;
    localparam logic [2:0] WR_FRONT = 3'd2;
    localparam logic [2:0] WR_UP    = 3'd3;
    localparam logic [2:0] WR_DOWN  = 3'd4;

    // count commands
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] frame_handle;
        logic [31:0] time_sec;
        logic [19:0] time_usec;
        logic [31:0] frame_interval_ns;
    } in_word_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [15:0]          out_handle;
        logic [CNT_OUT_W-1:0] out_count;
        logic [TIME_W-1:0]    match_distance_us;
    } out_word_t;

    typedef struct packed {
        logic       load_in;
        logic       calc_time;
        logic [2:0] ptr_op;
        logic [2:0] wr_op;
        logic [1:0] cnt_op;
        logic       scan_init;
        logic       scan_step;
        logic       tol_calc;
        logic       res_status_load;
        logic [2:0] res_status;
        logic       res_handle_load;
        logic       res_handle_best;
        logic       res_dist_load;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic       closed;
        logic       full;
        logic       empty;
        logic       ptr_zero;
        logic       ptr_at_top;
        logic       pos_last;
        logic       scan_stop;
        logic       nomatch;
        logic       out_busy;
    } stat_t;

endpackage

@@ rtl/core/ftmq_ctrl.sv @@
// sequencer of the frame timestamp match queue
module ftmq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  ftmq_pkg::stat_t stat,
    output ftmq_pkg::cmd_t  cmd
);
    import ftmq_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CALC     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_SHIFT_UP = 4'd3;
    localparam logic [3:0] S_INSERT   = 4'd4;
    localparam logic [3:0] S_POP      = 4'd5;
    localparam logic [3:0] S_SCAN     = 4'd6;
    localparam logic [3:0] S_TOL      = 4'd7;
    localparam logic [3:0] S_JUDGE    = 4'd8;
    localparam logic [3:0] S_SHIFT_DN = 4'd9;
    localparam logic [3:0] S_FIN      = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.ptr_op = PTR_HOLD;
        cmd.wr_op  = WR_NONE;
        cmd.cnt_op = CNT_HOLD;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.calc_time = 1'b1;
                state_next    = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                cmd.res_status_load = 1'b1;
                cmd.res_status      = ST_OK;
                state_next          = S_FIN;
                case (stat.opcode)
                    OP_PUSH_BACK, OP_PUSH_FRONT:
                    begin
                        if (stat.closed)
                            cmd.res_status = ST_CLOSED;
                        else if (stat.full)
                            cmd.res_status = ST_FULL;
                        else if (stat.opcode == OP_PUSH_BACK)
                        begin
                            cmd.wr_op  = WR_BACK;
                            cmd.cnt_op = CNT_INC;
                        end
                        else if (stat.empty)
                        begin
                            cmd.wr_op  = WR_FRONT;
                            cmd.cnt_op = CNT_INC;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_TOP;
                            state_next = S_SHIFT_UP;
                        end
                    end
                    OP_POP_BACK:
                    begin
                        if (stat.closed)
                            cmd.res_status = ST_CLOSED;
                        else if (stat.empty)
                            cmd.res_status = ST_EMPTY;
                        else
                        begin
                            cmd.ptr_op = PTR_TOP;
                            state_next = S_POP;
                        end
                    end
                    OP_MATCH:
                    begin
                        if (stat.empty)
                            cmd.res_status = ST_EMPTY;
                        else
                        begin
                            cmd.ptr_op    = PTR_ZERO;
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    default:
                    begin
                        // count query and unused codes only report the count
                        cmd.res_status = ST_OK;
                    end
                endcase
            end
            S_SHIFT_UP:
            begin
                cmd.wr_op = WR_UP;
                if (stat.ptr_zero)
                    state_next = S_INSERT;
                else
                    cmd.ptr_op = PTR_DEC;
            end
            S_INSERT:
            begin
                cmd.wr_op  = WR_FRONT;
                cmd.cnt_op = CNT_INC;
                state_next = S_FIN;
            end
            S_POP:
            begin
                cmd.res_handle_load = 1'b1;
                cmd.cnt_op          = CNT_DEC;
                state_next          = S_FIN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_stop)
                    state_next = S_TOL;
                else
                    cmd.ptr_op = PTR_INC;
            end
            S_TOL:
            begin
                cmd.tol_calc = 1'b1;
                state_next   = S_JUDGE;
            end
            S_JUDGE:
            begin
                cmd.res_dist_load   = 1'b1;
                cmd.res_status_load = 1'b1;
                state_next          = S_FIN;
                if (stat.nomatch)
                    cmd.res_status = ST_NOMATCH;
                else
                begin
                    cmd.res_status      = ST_OK;
                    cmd.res_handle_load = 1'b1;
                    cmd.res_handle_best = 1'b1;
                    if (stat.pos_last)
                        cmd.cnt_op = CNT_DEC;
                    else
                    begin
                        cmd.ptr_op = PTR_POS1;
                        state_next = S_SHIFT_DN;
                    end
                end
            end
            S_SHIFT_DN:
            begin
                cmd.wr_op = WR_DOWN;
                if (stat.ptr_at_top)
                begin
                    cmd.cnt_op = CNT_DEC;
                    state_next = S_FIN;
                end
                else
                    cmd.ptr_op = PTR_INC;
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/core/ftmq_datapath.sv @@
// entry store, match arithmetic and result register of the queue
`include "frame_timestamp_match_queue_macros.svh"

module ftmq_datapath #(
    parameter int QUEUE_DEPTH = ftmq_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS = ftmq_pkg::HANDLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ftmq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ftmq_pkg::CFG_DAT_W-1:0]    cfg_data,
    input  ftmq_pkg::in_word_t                in_word,
    input  ftmq_pkg::cmd_t                    cmd,
    output ftmq_pkg::stat_t                   stat,
    input  logic                              out_stall,
    output logic                              out_valid,
    output ftmq_pkg::out_word_t               out_word
);
    import ftmq_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int HB = HANDLE_BITS;

    // entry store
    logic [HB-1:0]     mem_handle [QUEUE_DEPTH];
    logic [TIME_W-1:0] mem_time   [QUEUE_DEPTH];
    logic [31:0]       mem_intv   [QUEUE_DEPTH];

    logic [HB-1:0]     rd_handle_reg;
    logic [TIME_W-1:0] rd_time_reg;
    logic [31:0]       rd_intv_reg;

    logic [4:0]        cap_reg;
    logic              closed_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [IW-1:0]     ptr_reg;
    logic [IW-1:0]     ptr_next;
    logic [IW-1:0]     pos_reg;

    in_word_t          in_reg;
    logic [TIME_W-1:0] t_reg;

    logic              scan_first_reg;
    logic [TIME_W-1:0] best_reg;
    logic [HB-1:0]     best_handle_reg;
    logic [31:0]       best_intv_reg;
    logic [32:0]       prod_reg;
    logic              big_reg;

    logic [2:0]        status_reg;
    logic [HB-1:0]     handle_reg;
    logic [TIME_W-1:0] dist_reg;
    logic              out_valid_reg;
    out_word_t         out_reg;

    logic [CW-1:0]     ptr_inc_c;
    logic [CW-1:0]     pos_inc_c;
    logic [CW-1:0]     cnt_dec_c;
    logic [31:0]       eff_limit_c;
    logic [TIME_W:0]   diff_c;
    logic [TIME_W-1:0] dist_c;
    logic              better_c;
    logic [TIME_W-1:0] best_new_c;
    logic              mem_we_c;
    logic [IW-1:0]     waddr_c;
    logic [HB-1:0]     wr_handle_c;
    logic [TIME_W-1:0] wr_time_c;
    logic [31:0]       wr_intv_c;
    logic [HB-1:0]     new_handle_c;
    logic [47:0]       in_handle_wide_c;
    logic [47:0]       out_handle_wide_c;
    logic [31:0]       cnt_wide_c;

    assign ptr_inc_c   = CW'(ptr_reg) + CW'(1);
    assign pos_inc_c   = CW'(pos_reg) + CW'(1);
    assign cnt_dec_c   = count_reg - CW'(1);
    assign eff_limit_c = ({27'd0, cap_reg} > 32'(QUEUE_DEPTH)) ? 32'(QUEUE_DEPTH)
                                                              : {27'd0, cap_reg};

    assign in_handle_wide_c = 48'(in_reg.frame_handle);
    assign new_handle_c     = in_handle_wide_c[HB-1:0];

    // distance of the entry under the pointer, borrow picks the sign
    assign diff_c     = {1'b0, rd_time_reg} - {1'b0, t_reg};
    assign dist_c     = diff_c[TIME_W] ? (t_reg - rd_time_reg) : diff_c[TIME_W-1:0];
    assign better_c   = scan_first_reg || (dist_c < best_reg);
    assign best_new_c = better_c ? dist_c : best_reg;

    always_comb
    begin
        case (cmd.ptr_op)
            PTR_TOP:  ptr_next = cnt_dec_c[IW-1:0];
            PTR_ZERO: ptr_next = '0;
            PTR_INC:  ptr_next = ptr_inc_c[IW-1:0];
            PTR_DEC:  ptr_next = ptr_reg - IW'(1);
            PTR_POS1: ptr_next = pos_inc_c[IW-1:0];
            default:  ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        mem_we_c    = 1'b1;
        waddr_c     = '0;
        wr_handle_c = new_handle_c;
        wr_time_c   = t_reg;
        wr_intv_c   = in_reg.frame_interval_ns;
        case (cmd.wr_op)
            WR_BACK:  waddr_c = count_reg[IW-1:0];
            WR_FRONT: waddr_c = '0;
            WR_UP:
            begin
                waddr_c     = ptr_inc_c[IW-1:0];
                wr_handle_c = rd_handle_reg;
                wr_time_c   = rd_time_reg;
                wr_intv_c   = rd_intv_reg;
            end
            WR_DOWN:
            begin
                waddr_c     = ptr_reg - IW'(1);
                wr_handle_c = rd_handle_reg;
                wr_time_c   = rd_time_reg;
                wr_intv_c   = rd_intv_reg;
            end
            default:  mem_we_c = 1'b0;
        endcase
    end

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = cnt_dec_c;
            default: count_next = count_reg;
        endcase
    end

    // one write and one registered read per cycle, read follows the pointer
    always_ff @(posedge clk)
    begin
        if (mem_we_c)
        begin
            mem_handle[waddr_c] <= wr_handle_c;
            mem_time[waddr_c]   <= wr_time_c;
            mem_intv[waddr_c]   <= wr_intv_c;
        end
        rd_handle_reg <= mem_handle[ptr_next];
        rd_time_reg   <= mem_time[ptr_next];
        rd_intv_reg   <= mem_intv[ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= CAP_RESET;
            closed_reg     <= 1'b0;
            count_reg      <= '0;
            ptr_reg        <= '0;
            scan_first_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CAPACITY: cap_reg    <= cfg_data;
                    CFG_CLOSED:   closed_reg <= cfg_data[0];
                    default:      ;
                endcase
            end
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            if (cmd.scan_init)
                scan_first_reg <= 1'b1;
            else if (cmd.scan_step)
                scan_first_reg <= 1'b0;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            in_reg <= in_word;
        if (cmd.calc_time)
            t_reg <= ({20'd0, in_reg.time_sec} * {32'd0, USEC_PER_SEC})
                     + {32'd0, in_reg.time_usec};
        if (cmd.scan_step && better_c)
        begin
            best_reg        <= dist_c;
            pos_reg         <= ptr_reg;
            best_handle_reg <= rd_handle_reg;
            best_intv_reg   <= rd_intv_reg;
        end
        // best <= interval / 2000 exactly when best * 2000 <= interval
        if (cmd.tol_calc)
        begin
            prod_reg <= {11'd0, best_reg[21:0]} * {22'd0, TOL_DIVISOR};
            big_reg  <= |best_reg[TIME_W-1:22];
        end
        if (cmd.res_status_load)
            status_reg <= cmd.res_status;
        if (cmd.res_handle_load)
            handle_reg <= cmd.res_handle_best ? best_handle_reg : rd_handle_reg;
        else if (cmd.res_status_load)
            handle_reg <= '0;
        if (cmd.res_dist_load)
            dist_reg <= best_reg;
        else if (cmd.res_status_load)
            dist_reg <= '0;
        if (cmd.out_load)
        begin
            out_reg.status            <= status_reg;
            out_reg.out_handle        <= out_handle_wide_c[15:0];
            out_reg.out_count         <= cnt_wide_c[CNT_OUT_W-1:0];
            out_reg.match_distance_us <= dist_reg;
        end
    end

    assign out_handle_wide_c = 48'(handle_reg);
    assign cnt_wide_c        = 32'(count_reg);

    assign stat.opcode     = in_reg.opcode;
    assign stat.closed     = closed_reg;
    assign stat.full       = (32'(count_reg) >= eff_limit_c);
    assign stat.empty      = (count_reg == '0);
    assign stat.ptr_zero   = (ptr_reg == '0);
    assign stat.ptr_at_top = (ptr_inc_c == count_reg);
    assign stat.pos_last   = (pos_inc_c == count_reg);
    assign stat.scan_stop  = (best_new_c < TIME_W'(EARLY_STOP_US)) || (ptr_inc_c == count_reg);
    assign stat.nomatch    = big_reg || (prod_reg > {1'b0, best_intv_reg});
    assign stat.out_busy   = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    `FTMQ_ASSERT_IMP(a_inc_room, clk, rst_n, cmd.cnt_op == CNT_INC,
        32'(count_reg) < 32'(QUEUE_DEPTH), "count grows past the store depth")
    `FTMQ_ASSERT_IMP(a_dec_nonempty, clk, rst_n, cmd.cnt_op == CNT_DEC,
        count_reg != '0, "count drops below zero")
    `FTMQ_ASSERT_IMP(a_up_in_range, clk, rst_n, cmd.wr_op == WR_UP,
        ptr_inc_c <= count_reg, "front shift writes beyond the occupied entries")
    `FTMQ_ASSERT_IMP(a_load_free, clk, rst_n, cmd.out_load,
        !(out_valid_reg && out_stall), "result word overwritten while held")

endmodule

@@ rtl/core/frame_timestamp_match_queue.sv @@
// top level of the frame timestamp match queue
//
// Ordered queue of up to QUEUE_DEPTH frame records (handle, time in us, interval
// in ns) with push back, push front, pop back, count and nearest-time match;
// one word in gives one result word out, and one word is handled at a time.
// All entries sit in a store with one write port and one registered read port
// (one write and one registered read per cycle), so every move through the
// queue goes entry by entry: push front shifts the entries back one place,
// starting from the back, before it writes the new front entry (an empty queue
// takes it directly), and match walks the entries from the front until the
// best distance is under 400 us or the queue ends, then moves the entries behind
// the taken one forward; a match with nothing in tolerance moves none. While
// the result register still holds a word that the receiver stalls, the next
// result waits and the input stays stalled. No clearing pass follows reset; the
// block takes words at once. Configuration writes belong to idle periods.
module frame_timestamp_match_queue #(
    parameter int QUEUE_DEPTH = ftmq_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS = ftmq_pkg::HANDLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ftmq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ftmq_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  ftmq_pkg::in_word_t             in_word,
    output logic                           out_valid,
    input  logic                           out_stall,
    output ftmq_pkg::out_word_t            out_word
);
    import ftmq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    ftmq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ftmq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .stat      (stat),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

endmodule

@@ sim/testbench.sv @@
// testbench of the frame timestamp match queue: directed and random words against a predictor
module testbench;
    import ftmq_pkg::*;

    localparam int DEPTH         = QUEUE_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    in_word_t             in_word;
    logic                 out_valid;
    logic                 out_stall;
    out_word_t            out_word;

    frame_timestamp_match_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // predicted queue contents and registers
    logic [15:0]       q_handle   [DEPTH];
    logic [TIME_W-1:0] q_time     [DEPTH];
    logic [31:0]       q_interval [DEPTH];
    int                q_count;
    logic [4:0]        cap_limit;
    logic              closed_flag;

    out_word_t awaited_replies [$];
    int        mismatches;
    int        send_idle_pct;
    int        stall_pct;
    int        hold_left;

    // time window the random frames cluster around
    logic [31:0] base_sec;
    int          base_usec;
    logic [31:0] last_sec;
    logic [19:0] last_usec;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic out_word_t apply_frame_op(input in_word_t w);
        out_word_t   r;
        logic [63:0] t;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] best;
        int          lim;
        int          pos;
        int          i;
        logic        stop;
        r = '0;
        r.status = ST_OK;
        t = 64'(w.time_sec) * 64'(USEC_PER_SEC) + 64'(w.time_usec);
        t = t & {12'd0, {TIME_W{1'b1}}};
        lim = (cap_limit > DEPTH) ? DEPTH : int'(cap_limit);
        case (w.opcode)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (closed_flag)
                    r.status = ST_CLOSED;
                else if (q_count >= lim)
                    r.status = ST_FULL;
                else if (w.opcode == OP_PUSH_BACK)
                begin
                    q_handle[q_count]   = w.frame_handle;
                    q_time[q_count]     = t[TIME_W-1:0];
                    q_interval[q_count] = w.frame_interval_ns;
                    q_count++;
                end
                else
                begin
                    for (i = q_count; i > 0; i--)
                    begin
                        q_handle[i]   = q_handle[i-1];
                        q_time[i]     = q_time[i-1];
                        q_interval[i] = q_interval[i-1];
                    end
                    q_handle[0]   = w.frame_handle;
                    q_time[0]     = t[TIME_W-1:0];
                    q_interval[0] = w.frame_interval_ns;
                    q_count++;
                end
            end
            OP_POP_BACK:
            begin
                if (closed_flag)
                    r.status = ST_CLOSED;
                else if (q_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.out_handle = q_handle[q_count-1];
                    q_count--;
                end
            end
            OP_MATCH:
            begin
                if (q_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    best = '1;
                    pos  = 0;
                    stop = 1'b0;
                    // first strictly nearer entry wins, walk ends once under the early-stop bound
                    for (i = 0; i < q_count && !stop; i++)
                    begin
                        e = 64'(q_time[i]);
                        d = (e >= t) ? e - t : t - e;
                        if (d < best)
                        begin
                            best = d;
                            pos  = i;
                        end
                        if (best < 64'(EARLY_STOP_US))
                            stop = 1'b1;
                    end
                    r.match_distance_us = (best > 64'({TIME_W{1'b1}})) ?
                                          {TIME_W{1'b1}} : best[TIME_W-1:0];
                    if (best > 64'(q_interval[pos]) / 64'(TOL_DIVISOR))
                        r.status = ST_NOMATCH;
                    else
                    begin
                        r.out_handle = q_handle[pos];
                        for (i = pos; i + 1 < q_count; i++)
                        begin
                            q_handle[i]   = q_handle[i+1];
                            q_time[i]     = q_time[i+1];
                            q_interval[i] = q_interval[i+1];
                        end
                        q_count--;
                    end
                end
            end
            default: ;
        endcase
        r.out_count = CNT_OUT_W'(q_count);
        return r;
    endfunction

    function automatic in_word_t frame_word(input logic [2:0] op, input logic [15:0] handle,
                                            input logic [31:0] sec, input logic [19:0] usec,
                                            input logic [31:0] interval);
        in_word_t w;
        w.opcode            = op;
        w.frame_handle      = handle;
        w.time_sec          = sec;
        w.time_usec         = usec;
        w.frame_interval_ns = interval;
        return w;
    endfunction

    function automatic in_word_t random_frame_word();
        in_word_t w;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 32)
            w.opcode = OP_PUSH_BACK;
        else if (pick < 50)
            w.opcode = OP_PUSH_FRONT;
        else if (pick < 63)
            w.opcode = OP_POP_BACK;
        else if (pick < 67)
            w.opcode = OP_COUNT;
        else if (pick < 96)
            w.opcode = OP_MATCH;
        else
            w.opcode = 3'($urandom_range(5, 7));
        w.frame_handle = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 72)
        begin
            w.time_sec  = base_sec;
            w.time_usec = 20'(base_usec + int'($urandom_range(0, 40000)));
        end
        else if (pick < 85)
        begin
            // same time as an earlier push, hits the early stop and ties
            w.time_sec  = last_sec;
            w.time_usec = last_usec;
        end
        else
        begin
            w.time_sec  = $urandom;
            w.time_usec = 20'($urandom_range(0, 20'hFFFFF));
        end
        pick = $urandom_range(0, 99);
        if (pick < 40)
            w.frame_interval_ns = 32'd33333333;
        else if (pick < 60)
            w.frame_interval_ns = 32'd16666666;
        else if (pick < 75)
            w.frame_interval_ns = 32'd100000000;
        else if (pick < 85)
            w.frame_interval_ns = 32'd0;
        else
            w.frame_interval_ns = $urandom;
        if (w.opcode == OP_PUSH_BACK || w.opcode == OP_PUSH_FRONT)
        begin
            last_sec  = w.time_sec;
            last_usec = w.time_usec;
        end
        return w;
    endfunction

    // entered just after a rising edge; leaves valid high after acceptance
    task automatic send_word(input in_word_t w);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        awaited_replies.push_back(apply_frame_op(w));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CAPACITY)
            cap_limit = val;
        else if (idx == CFG_CLOSED)
            closed_flag = val[0];
    endtask

    task automatic test_basic_ops();
        send_word(frame_word(OP_COUNT, 16'h0, 32'd0, 20'd0, 32'd0));
        send_word(frame_word(OP_POP_BACK, 16'h0, 32'd0, 20'd0, 32'd0));
        send_word(frame_word(OP_MATCH, 16'h0, 32'd0, 20'd0, 32'd0));
        send_word(frame_word(OP_PUSH_BACK, 16'h0000, 32'd0, 20'd0, 32'd0));
        // largest seconds with an out-of-range usec
        send_word(frame_word(OP_PUSH_BACK, 16'hFFFF, 32'hFFFFFFFF, 20'hFFFFF, 32'hFFFFFFFF));
        send_word(frame_word(OP_PUSH_FRONT, 16'h1234, 32'd100, 20'd500000, 32'd33333333));
        send_word(frame_word(OP_PUSH_BACK, 16'h5678, 32'd100, 20'd500000, 32'd33333333));
        // near the front, walk stops at once
        send_word(frame_word(OP_MATCH, 16'h0, 32'd100, 20'd500100, 32'd0));
        // outside the tolerance
        send_word(frame_word(OP_MATCH, 16'h0, 32'd100, 20'd520000, 32'd0));
        // zero distance against a zero interval
        send_word(frame_word(OP_MATCH, 16'h0, 32'd0, 20'd0, 32'd0));
        send_word(frame_word(OP_PUSH_BACK, 16'hAAAA, 32'd100, 20'd510000, 32'd33333333));
        // equal distance on two entries, the first one is taken
        send_word(frame_word(OP_MATCH, 16'h0, 32'd100, 20'd505000, 32'd0));
        send_word(frame_word(OP_MATCH, 16'hFFFF, 32'hFFFFFFFF, 20'hFFFFF, 32'hFFFFFFFF));
        send_word(frame_word(3'd5, 16'h0, 32'd0, 20'd0, 32'd0));
        send_word(frame_word(3'd6, 16'hFFFF, 32'hFFFFFFFF, 20'hFFFFF, 32'hFFFFFFFF));
        send_word(frame_word(3'd7, 16'h0, 32'd0, 20'd0, 32'd0));
        send_word(frame_word(OP_POP_BACK, 16'h0, 32'd0, 20'd0, 32'd0));
        wait_idle();
    endtask

    task automatic test_full_queue();
        write_reg(CFG_CAPACITY, 5'd2);
        send_word(frame_word(OP_PUSH_BACK, 16'h0101, 32'd7, 20'd1, 32'd1000));
        send_word(frame_word(OP_PUSH_BACK, 16'h0202, 32'd7, 20'd2, 32'd1000));
        send_word(frame_word(OP_PUSH_BACK, 16'h0303, 32'd7, 20'd3, 32'd1000));
        send_word(frame_word(OP_PUSH_FRONT, 16'h0404, 32'd7, 20'd4, 32'd1000));
        send_word(frame_word(OP_POP_BACK, 16'h0, 32'd0, 20'd0, 32'd0));
        send_word(frame_word(OP_PUSH_FRONT, 16'h0505, 32'd7, 20'd5, 32'd1000));
        // shrinking the limit below the fill leaves the queue full
        write_reg(CFG_CAPACITY, 5'd0);
        send_word(frame_word(OP_PUSH_BACK, 16'h0606, 32'd7, 20'd6, 32'd1000));
        send_word(frame_word(OP_COUNT, 16'h0, 32'd0, 20'd0, 32'd0));
        wait_idle();
    endtask

    task automatic test_closed_queue();
        write_reg(CFG_CLOSED, 5'd1);
        send_word(frame_word(OP_PUSH_BACK, 16'h0707, 32'd7, 20'd7, 32'd1000));
        send_word(frame_word(OP_PUSH_FRONT, 16'h0808, 32'd7, 20'd8, 32'd1000));
        send_word(frame_word(OP_POP_BACK, 16'h0, 32'd0, 20'd0, 32'd0));
        send_word(frame_word(OP_MATCH, 16'h0, 32'd7, 20'd5, 32'd0));
        send_word(frame_word(OP_COUNT, 16'h0, 32'd0, 20'd0, 32'd0));
        write_reg(CFG_CLOSED, 5'd0);
    endtask

    task automatic test_random_traffic(input logic [4:0] cap, input logic closed,
                                       input int idle_pct, input int stall_in, input int n);
        int k;
        write_reg(CFG_CAPACITY, cap);
        write_reg(CFG_CLOSED, {4'd0, closed});
        send_idle_pct = idle_pct;
        stall_pct     = stall_in;
        base_sec      = $urandom;
        base_usec     = $urandom_range(0, 950000);
        last_sec      = base_sec;
        last_usec     = 20'(base_usec);
        for (k = 0; k < n; k++)
            send_word(random_frame_word());
        wait_idle();
    endtask

    task automatic test_backpressure();
        wait_idle();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 400;
        repeat (40) send_word(random_frame_word());
        wait_idle();
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // receiver side: random stall, or a long hold-off while the sender keeps offering
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word with nothing awaited: %0h", out_word);
            end
            else
            begin
                want = awaited_replies.pop_front();
                check_field("status", 64'(want.status), 64'(out_word.status));
                check_field("out_handle", 64'(want.out_handle), 64'(out_word.out_handle));
                check_field("out_count", 64'(want.out_count), 64'(out_word.out_count));
                check_field("match_distance_us", 64'(want.match_distance_us),
                            64'(out_word.match_distance_us));
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL frame_timestamp_match_queue");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_word       = '0;
        out_stall     = 1'b0;
        mismatches    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 0;
        q_count       = 0;
        cap_limit     = CAP_RESET;
        closed_flag   = 1'b0;
        base_sec      = '0;
        base_usec     = 0;
        last_sec      = '0;
        last_usec     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_full_queue();
        test_closed_queue();
        test_random_traffic(5'd16, 1'b0, 0, 0, 220);
        test_random_traffic(5'd31, 1'b0, 79, 0, 200);
        test_random_traffic(5'($urandom_range(1, 15)), 1'b0, 0, 79, 200);
        test_random_traffic(5'd16, 1'b1, 19, 19, 60);
        test_random_traffic(5'd16, 1'b0, 19, 19, 200);
        test_backpressure();

        wait_idle();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("PASS frame_timestamp_match_queue");
        else
            $display("FAIL frame_timestamp_match_queue");
        $finish;
    end

endmodule
